>>> src/sharpen_edge_3x3_filter_defines.svh
// Assertion macros shared by the sharpen filter RTL.
// No dependencies; included by the files that carry concurrent checks.
`ifndef SHARPEN_EDGE_3X3_FILTER_DEFINES_SVH
`define SHARPEN_EDGE_3X3_FILTER_DEFINES_SVH

// Implication or plain property, checked on every rising clock edge outside reset
`define SEF_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Condition that must never be seen
`define SEF_NEVER(lbl, expr, msg) \
   `SEF_ASSERT(lbl, !(expr), msg)

`endif

>>> src/sef_pkg.sv
// Types and constants for the 3x3 sharpen filter.
// No dependencies; used by scoped names in the kernel, queue, top level and testbench.
package sef_pkg;

   // Frame geometry and pixel format
   localparam int MAX_WIDTH  = 512;
   localparam int MAX_HEIGHT = 4096;
   localparam int PIXEL_BITS = 16;
   localparam int PIX_W      = 16;
   localparam int LINE_W     = 2 * PIX_W;
   localparam int ADDR_W     = $clog2(MAX_WIDTH);
   localparam int ROW_W      = 12;
   localparam int COL_W      = 9;
   localparam int WIDTH_W    = 10;
   localparam int HEIGHT_W   = 13;
   localparam int CSR_DATA_W = 16;
   localparam int CSR_IDX_W  = 2;
   localparam int SUM_W      = 23;

   localparam logic [PIX_W-1:0] PIXEL_MASK = PIX_W'((1 << PIXEL_BITS) - 1);

   // Register reset values
   localparam logic [WIDTH_W-1:0]  WIDTH_RESET  = WIDTH_W'(512);
   localparam logic [HEIGHT_W-1:0] HEIGHT_RESET = HEIGHT_W'(512);
   localparam logic [PIX_W-1:0]    MAXV_RESET   = PIX_W'(255);

   // Result queue sizing
   localparam int RSP_DEPTH = 4;
   localparam int RSP_PTR_W = $clog2(RSP_DEPTH);
   localparam int RSP_CNT_W = $clog2(RSP_DEPTH + 1);

   // Register indexes
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_IMAGE_WIDTH  = 2'd0,
      CSR_IMAGE_HEIGHT = 2'd1,
      CSR_MAX_VALUE    = 2'd2
   } csr_index_type;

   // Two previous columns of the 3x3 window
   typedef struct packed {
      logic [PIX_W-1:0] up2_left;
      logic [PIX_W-1:0] up2_mid;
      logic [PIX_W-1:0] up1_left;
      logic [PIX_W-1:0] center;
      logic [PIX_W-1:0] cur_left;
      logic [PIX_W-1:0] cur_mid;
   } window_type;

   // One result word
   typedef struct packed {
      logic [ROW_W-1:0] row;
      logic [COL_W-1:0] col;
      logic [PIX_W-1:0] value;
      logic             frame_done;
      logic             run_last;
   } rsp_word_type;

endpackage

>>> src/sef_ram.sv
// Generic single-write, single-read synchronous RAM with registered read.
// No dependencies; holds the line buffers of the sharpen filter.
module sef_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 512
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Read returns the old contents on a same-address write
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> src/sef_kernel.sv
// Sharpen kernel: weighted 3x3 sum and clamp to 0..max_value.
// Depends on sef_pkg for the window type and widths.
module sef_kernel (
   input  sef_pkg::window_type           win,
   input  logic [sef_pkg::PIX_W-1:0]     two_up,
   input  logic [sef_pkg::PIX_W-1:0]     one_up,
   input  logic [sef_pkg::PIX_W-1:0]     pixel,
   input  logic [sef_pkg::PIX_W-1:0]     max_value,
   output logic [sef_pkg::PIX_W-1:0]     value
);

   logic [sef_pkg::PIX_W+1:0] corners;
   logic [sef_pkg::PIX_W+1:0] edges;
   logic [sef_pkg::SUM_W-1:0] sum;

   // Corners weigh -1, edge neighbors -4, center 20
   always_comb begin
      corners = (sef_pkg::PIX_W+2)'(win.up2_left) + (sef_pkg::PIX_W+2)'(two_up)
              + (sef_pkg::PIX_W+2)'(win.cur_left) + (sef_pkg::PIX_W+2)'(pixel);
      edges   = (sef_pkg::PIX_W+2)'(win.up2_mid) + (sef_pkg::PIX_W+2)'(win.up1_left)
              + (sef_pkg::PIX_W+2)'(one_up) + (sef_pkg::PIX_W+2)'(win.cur_mid);
      sum     = sef_pkg::SUM_W'({win.center, 4'b0000})
              + sef_pkg::SUM_W'({win.center, 2'b00})
              - sef_pkg::SUM_W'({edges, 2'b00})
              - sef_pkg::SUM_W'(corners);
   end

   // Clamp: negative to zero, above max_value to max_value
   always_comb begin
      if (sum[sef_pkg::SUM_W-1]) begin
         value = '0;
      end else if (sum[sef_pkg::SUM_W-2:0] > (sef_pkg::SUM_W-1)'(max_value)) begin
         value = max_value;
      end else begin
         value = sum[sef_pkg::PIX_W-1:0];
      end
   end

endmodule

>>> src/sef_rsp_fifo.sv
// Result queue: takes up to two words per cycle, hands out one.
// Depends on sef_pkg and the assertion macros header.
`include "sharpen_edge_3x3_filter_defines.svh"

module sef_rsp_fifo (
   input  logic                            clock,
   input  logic                            reset,
   input  logic [1:0]                      push_cnt,
   input  sef_pkg::rsp_word_type           push_first,
   input  sef_pkg::rsp_word_type           push_second,
   output logic [sef_pkg::RSP_CNT_W-1:0]   count,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output sef_pkg::rsp_word_type           rsp_word
);

   sef_pkg::rsp_word_type                 mem_ff [sef_pkg::RSP_DEPTH];
   logic [sef_pkg::RSP_PTR_W-1:0]         wr_ptr_ff, wr_ptr_in;
   logic [sef_pkg::RSP_PTR_W-1:0]         rd_ptr_ff, rd_ptr_in;
   logic [sef_pkg::RSP_CNT_W-1:0]         count_ff, count_in;
   logic [sef_pkg::RSP_PTR_W-1:0]         wr_next;
   logic                                  pop;

   assign pop       = rsp_valid && rsp_ready;
   assign wr_next   = wr_ptr_ff + 1'b1;
   assign rsp_valid = (count_ff != '0);
   assign rsp_word  = mem_ff[rd_ptr_ff];
   assign count     = count_ff;

   // Pointer and fill bookkeeping
   always_comb begin
      wr_ptr_in = wr_ptr_ff + sef_pkg::RSP_PTR_W'(push_cnt);
      rd_ptr_in = rd_ptr_ff + sef_pkg::RSP_PTR_W'(pop);
      count_in  = count_ff + sef_pkg::RSP_CNT_W'(push_cnt) - sef_pkg::RSP_CNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Storage: first word at the tail, second right behind it
   always_ff @(posedge clock) begin
      if (push_cnt != 2'd0) begin
         mem_ff[wr_ptr_ff] <= push_first;
      end
      if (push_cnt == 2'd2) begin
         mem_ff[wr_next] <= push_second;
      end
   end

   `SEF_NEVER(a_push_overflow, ({1'b0, count_ff} + 4'(push_cnt)) > (4'(sef_pkg::RSP_DEPTH) + 4'(pop)), "result queue overflow")
   `SEF_NEVER(a_count_bound, count_ff > sef_pkg::RSP_CNT_W'(sef_pkg::RSP_DEPTH), "result queue count out of range")

endmodule

>>> src/sharpen_edge_3x3_filter.sv
// 3x3 sharpen filter over a raster pixel stream; top level.
// An accepted word waits in stage one until the queue has room for two words.
// Throughput: one pixel per cycle while the queue has room; the line RAM is read on
// accept, written back on advance; two-result pixels drain one word per ready cycle.
// Reset clears counters, window, queue and registers (width 512, height 512,
// max 255); line buffers are not cleared, each entry is written before use.
// Depends on sef_pkg, sef_ram, sef_kernel, sef_rsp_fifo and the macros header.
`include "sharpen_edge_3x3_filter_defines.svh"

module sharpen_edge_3x3_filter (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic [sef_pkg::PIX_W-1:0]          req_pixel_in,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic [sef_pkg::ROW_W-1:0]          rsp_out_row,
   output logic [sef_pkg::COL_W-1:0]          rsp_out_col,
   output logic [sef_pkg::PIX_W-1:0]          rsp_out_value,
   output logic                               rsp_frame_done,
   output logic                               rsp_run_last,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [sef_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [sef_pkg::CSR_DATA_W-1:0]     csr_data
);

   // Configuration registers
   logic [sef_pkg::WIDTH_W-1:0]  width_ff;
   logic [sef_pkg::HEIGHT_W-1:0] height_ff;
   logic [sef_pkg::PIX_W-1:0]    maxv_ff;
   logic [sef_pkg::WIDTH_W-1:0]  eff_width;
   logic [sef_pkg::HEIGHT_W-1:0] eff_height;

   // Position counters
   logic [sef_pkg::ROW_W-1:0] row_ff, row_in;
   logic [sef_pkg::COL_W-1:0] col_ff, col_in;
   logic                      last_col, last_row;

   // Stage one: item waiting for its line-buffer data
   logic                      s1_valid_ff, s1_valid_in;
   logic [sef_pkg::PIX_W-1:0] s1_pixel_ff;
   logic [sef_pkg::ROW_W-1:0] s1_row_ff;
   logic [sef_pkg::COL_W-1:0] s1_col_ff;
   logic                      s1_last_col_ff, s1_last_row_ff;
   logic                      s1_interior_ff, s1_border_ff;
   logic                      s1_adv;
   logic                      accept;

   // Line buffer access and same-entry forwarding
   logic [sef_pkg::LINE_W-1:0] ram_rd_data;
   logic [sef_pkg::LINE_W-1:0] line_data;
   logic [sef_pkg::LINE_W-1:0] wb_data;
   logic                       fwd_valid_ff, fwd_valid_in;
   logic [sef_pkg::LINE_W-1:0] fwd_data_ff;
   logic [sef_pkg::PIX_W-1:0]  two_up, one_up;

   sef_pkg::window_type       win_ff, win_in;
   logic [sef_pkg::PIX_W-1:0] kernel_value;

   // Result queue
   sef_pkg::rsp_word_type         word_interior, word_border;
   sef_pkg::rsp_word_type         push_first, push_second;
   sef_pkg::rsp_word_type         rsp_word;
   logic [1:0]                    push_cnt;
   logic [sef_pkg::RSP_CNT_W-1:0] fifo_count;

   // Register writes; never stalled
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= sef_pkg::WIDTH_RESET;
         height_ff <= sef_pkg::HEIGHT_RESET;
         maxv_ff   <= sef_pkg::MAXV_RESET;
      end else if (csr_valid && csr_ready) begin
         case (sef_pkg::csr_index_type'(csr_index))
            sef_pkg::CSR_IMAGE_WIDTH:  width_ff  <= csr_data[sef_pkg::WIDTH_W-1:0];
            sef_pkg::CSR_IMAGE_HEIGHT: height_ff <= csr_data[sef_pkg::HEIGHT_W-1:0];
            sef_pkg::CSR_MAX_VALUE:    maxv_ff   <= csr_data[sef_pkg::PIX_W-1:0];
            default: ;
         endcase
      end
   end

   // Effective frame size: zero acts as one, oversize clips to the maximum
   always_comb begin
      if (width_ff == '0) begin
         eff_width = sef_pkg::WIDTH_W'(1);
      end else if (width_ff > sef_pkg::WIDTH_W'(sef_pkg::MAX_WIDTH)) begin
         eff_width = sef_pkg::WIDTH_W'(sef_pkg::MAX_WIDTH);
      end else begin
         eff_width = width_ff;
      end
      if (height_ff == '0) begin
         eff_height = sef_pkg::HEIGHT_W'(1);
      end else if (height_ff > sef_pkg::HEIGHT_W'(sef_pkg::MAX_HEIGHT)) begin
         eff_height = sef_pkg::HEIGHT_W'(sef_pkg::MAX_HEIGHT);
      end else begin
         eff_height = height_ff;
      end
   end

   // Handshake: stage one moves on when the queue has room for two words
   assign s1_adv    = s1_valid_ff && (fifo_count <= sef_pkg::RSP_CNT_W'(sef_pkg::RSP_DEPTH - 2));
   assign req_ready = !s1_valid_ff || s1_adv;
   assign accept    = req_valid && req_ready;

   // Raster position of the arriving pixel
   always_comb begin
      last_col = ((sef_pkg::WIDTH_W'(col_ff) + 1'b1) >= eff_width);
      last_row = ((sef_pkg::HEIGHT_W'(row_ff) + 1'b1) >= eff_height);
      col_in   = col_ff;
      row_in   = row_ff;
      if (accept) begin
         if (last_col) begin
            col_in = '0;
            row_in = last_row ? '0 : row_ff + 1'b1;
         end else begin
            col_in = col_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_ff <= '0;
         col_ff <= '0;
      end else begin
         row_ff <= row_in;
         col_ff <= col_in;
      end
   end

   // Stage one control
   assign s1_valid_in = accept ? 1'b1 : (s1_adv ? 1'b0 : s1_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   // Stage one payload
   always_ff @(posedge clock) begin
      if (accept) begin
         s1_pixel_ff    <= req_pixel_in & sef_pkg::PIXEL_MASK;
         s1_row_ff      <= row_ff;
         s1_col_ff      <= col_ff;
         s1_last_col_ff <= last_col;
         s1_last_row_ff <= last_row;
         s1_interior_ff <= (row_ff >= sef_pkg::ROW_W'(2)) && (col_ff >= sef_pkg::COL_W'(2));
         s1_border_ff   <= (row_ff == '0) || (col_ff == '0) || last_col || last_row;
      end
   end

   // Line buffers: {two rows up, one row up}, read on accept, written on advance
   sef_ram #(
      .WIDTH (sef_pkg::LINE_W),
      .DEPTH (sef_pkg::MAX_WIDTH)
   ) u_line_ram (
      .clock   (clock),
      .wr_en   (s1_adv),
      .wr_addr (s1_col_ff[sef_pkg::ADDR_W-1:0]),
      .wr_data (wb_data),
      .rd_en   (accept),
      .rd_addr (col_ff[sef_pkg::ADDR_W-1:0]),
      .rd_data (ram_rd_data)
   );

   // Forward the write-back when the next pixel reads the entry being written
   assign fwd_valid_in = accept ? (s1_adv && (col_ff == s1_col_ff))
                                : (s1_adv ? 1'b0 : fwd_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         fwd_valid_ff <= 1'b0;
      end else begin
         fwd_valid_ff <= fwd_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         fwd_data_ff <= wb_data;
      end
   end

   assign line_data = fwd_valid_ff ? fwd_data_ff : ram_rd_data;
   assign two_up    = line_data[sef_pkg::LINE_W-1:sef_pkg::PIX_W];
   assign one_up    = line_data[sef_pkg::PIX_W-1:0];
   assign wb_data   = {one_up, s1_pixel_ff};

   // Window of the two previous columns, shifted once per pixel
   always_comb begin
      win_in = win_ff;
      if (s1_adv) begin
         win_in.up2_left = win_ff.up2_mid;
         win_in.up2_mid  = two_up;
         win_in.up1_left = win_ff.center;
         win_in.center   = one_up;
         win_in.cur_left = win_ff.cur_mid;
         win_in.cur_mid  = s1_pixel_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         win_ff <= '0;
      end else begin
         win_ff <= win_in;
      end
   end

   sef_kernel u_kernel (
      .win       (win_ff),
      .two_up    (two_up),
      .one_up    (one_up),
      .pixel     (s1_pixel_ff),
      .max_value (maxv_ff),
      .value     (kernel_value)
   );

   // Result words: the interior pixel up-left goes ahead of the border pass-through
   always_comb begin
      word_interior.row        = s1_row_ff - 1'b1;
      word_interior.col        = s1_col_ff - 1'b1;
      word_interior.value      = kernel_value;
      word_interior.frame_done = 1'b0;
      word_interior.run_last   = !s1_border_ff;
      word_border.row          = s1_row_ff;
      word_border.col          = s1_col_ff;
      word_border.value        = s1_pixel_ff;
      word_border.frame_done   = s1_last_row_ff && s1_last_col_ff;
      word_border.run_last     = 1'b1;
      push_first  = s1_interior_ff ? word_interior : word_border;
      push_second = word_border;
      push_cnt    = s1_adv ? (2'(s1_interior_ff) + 2'(s1_border_ff)) : 2'd0;
   end

   sef_rsp_fifo u_rsp_fifo (
      .clock       (clock),
      .reset       (reset),
      .push_cnt    (push_cnt),
      .push_first  (push_first),
      .push_second (push_second),
      .count       (fifo_count),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_word    (rsp_word)
   );

   assign rsp_out_row    = rsp_word.row;
   assign rsp_out_col    = rsp_word.col;
   assign rsp_out_value  = rsp_word.value;
   assign rsp_frame_done = rsp_word.frame_done;
   assign rsp_run_last   = rsp_word.run_last;

   `SEF_ASSERT(a_fwd_in_s1, fwd_valid_ff |-> s1_valid_ff, "forwarded data, stage one empty")
   `SEF_NEVER(a_done_is_last, rsp_valid && rsp_frame_done && !rsp_run_last, "frame end not last")

endmodule

>>> dv/tb_sharpen_edge_3x3_filter.sv
// Self-checking testbench for the 3x3 sharpen filter: drives pixel frames and
// register writes, predicts every result word and checks it in order.
// Depends on sef_pkg and the sharpen_edge_3x3_filter RTL.
`timescale 1ns / 1ps

module tb_sharpen_edge_3x3_filter;

   // Unused register slot, writes must have no effect
   localparam logic [sef_pkg::CSR_IDX_W-1:0] CSR_SPARE_INDEX = 2'd3;
   // Cycles to let a word with no result settle before a register write
   localparam int SETTLE_CYCLES = 8;
   // Receiver hold-off used to back up the result queue
   localparam int HOLD_CYCLES = 150;

   typedef enum int {PIX_ANY, PIX_LOW, PIX_EXTREME, PIX_MID} pixel_mode_type;
   typedef enum int {READY_ALWAYS, READY_COIN, READY_PERIODIC, READY_SPARSE} ready_mode_type;

   // Frame model plus queue of expected result words
   class sharpen_scoreboard;
      logic [sef_pkg::PIX_W-1:0] line_up2 [sef_pkg::MAX_WIDTH];
      logic [sef_pkg::PIX_W-1:0] line_up1 [sef_pkg::MAX_WIDTH];
      logic [sef_pkg::PIX_W-1:0] win [6];
      int unsigned row_pos;
      int unsigned col_pos;
      logic [sef_pkg::WIDTH_W-1:0] width_reg;
      logic [sef_pkg::HEIGHT_W-1:0] height_reg;
      logic [sef_pkg::PIX_W-1:0] clamp_reg;
      sef_pkg::rsp_word_type expected_q [$];
      int errors;

      function new();
         foreach (line_up2[i]) begin
            line_up2[i] = '0;
            line_up1[i] = '0;
         end
         foreach (win[i]) win[i] = '0;
         row_pos = 0;
         col_pos = 0;
         width_reg = sef_pkg::WIDTH_RESET;
         height_reg = sef_pkg::HEIGHT_RESET;
         clamp_reg = sef_pkg::MAXV_RESET;
         errors = 0;
      endfunction

      // Width and height as the block applies them
      function int unsigned cols_now();
         if (width_reg == 0) return 1;
         if (width_reg > sef_pkg::MAX_WIDTH) return sef_pkg::MAX_WIDTH;
         return width_reg;
      endfunction

      function int unsigned rows_now();
         if (height_reg == 0) return 1;
         if (height_reg > sef_pkg::MAX_HEIGHT) return sef_pkg::MAX_HEIGHT;
         return height_reg;
      endfunction

      function void write_reg(logic [sef_pkg::CSR_IDX_W-1:0] idx,
                              logic [sef_pkg::CSR_DATA_W-1:0] d);
         case (idx)
            sef_pkg::CSR_IMAGE_WIDTH: width_reg = d[sef_pkg::WIDTH_W-1:0];
            sef_pkg::CSR_IMAGE_HEIGHT: height_reg = d[sef_pkg::HEIGHT_W-1:0];
            sef_pkg::CSR_MAX_VALUE: clamp_reg = d;
            default: ;
         endcase
      endfunction

      function int unsigned outstanding();
         return expected_q.size();
      endfunction

      // Accepted pixel: queue the interior result it completes, then its border word
      function void note_pixel(logic [sef_pkg::PIX_W-1:0] pix);
         int unsigned w, h, r, c;
         logic [sef_pkg::PIX_W-1:0] a, b, v;
         bit last_col, last_row, border;
         int corners, edges, total;
         sef_pkg::rsp_word_type wd;
         w = cols_now();
         h = rows_now();
         r = row_pos;
         c = col_pos;
         a = line_up2[c];
         b = line_up1[c];
         last_col = (c + 1 >= w);
         last_row = (r + 1 >= h);
         border = (r == 0) || (c == 0) || last_col || last_row;

         if (r >= 2 && c >= 2) begin
            corners = int'(win[0]) + int'(a) + int'(win[4]) + int'(pix);
            edges = int'(win[1]) + int'(win[2]) + int'(b) + int'(win[5]);
            total = 20 * int'(win[3]) - 4 * edges - corners;
            if (total < 0) v = '0;
            else if (total > int'(clamp_reg)) v = clamp_reg;
            else v = total[sef_pkg::PIX_W-1:0];
            wd.row = sef_pkg::ROW_W'(r - 1);
            wd.col = sef_pkg::COL_W'(c - 1);
            wd.value = v;
            wd.frame_done = 1'b0;
            wd.run_last = !border;
            expected_q.push_back(wd);
         end

         if (border) begin
            wd.row = sef_pkg::ROW_W'(r);
            wd.col = sef_pkg::COL_W'(c);
            wd.value = pix;
            wd.frame_done = last_row && last_col;
            wd.run_last = 1'b1;
            expected_q.push_back(wd);
         end

         // Shift the window and roll the line buffers
         win[0] = win[1];
         win[1] = a;
         win[2] = win[3];
         win[3] = b;
         win[4] = win[5];
         win[5] = pix;
         line_up2[c] = b;
         line_up1[c] = pix;

         if (last_col) begin
            col_pos = 0;
            row_pos = last_row ? 0 : r + 1;
         end else begin
            col_pos = c + 1;
         end
      endfunction

      function void flag_field(string field, logic [sef_pkg::PIX_W-1:0] want,
                               logic [sef_pkg::PIX_W-1:0] got);
         errors++;
         $display("%0t: %s mismatch, expected %h, actual %h", $time, field, want, got);
      endfunction

      // Accepted result word: compare with the oldest expectation
      function void check(sef_pkg::rsp_word_type got);
         sef_pkg::rsp_word_type want;
         if (expected_q.size() == 0) begin
            errors++;
            $display("%0t: unexpected word, expected none, actual row %0d col %0d value %h",
                     $time, got.row, got.col, got.value);
            return;
         end
         want = expected_q.pop_front();
         if (got.row !== want.row) flag_field("row", want.row, got.row);
         if (got.col !== want.col) flag_field("col", want.col, got.col);
         if (got.value !== want.value) flag_field("value", want.value, got.value);
         if (got.frame_done !== want.frame_done)
            flag_field("frame_done", want.frame_done, got.frame_done);
         if (got.run_last !== want.run_last) flag_field("run_last", want.run_last, got.run_last);
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic [sef_pkg::PIX_W-1:0] req_pixel_in = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic [sef_pkg::ROW_W-1:0] rsp_out_row;
   logic [sef_pkg::COL_W-1:0] rsp_out_col;
   logic [sef_pkg::PIX_W-1:0] rsp_out_value;
   logic rsp_frame_done;
   logic rsp_run_last;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [sef_pkg::CSR_IDX_W-1:0] csr_index = '0;
   logic [sef_pkg::CSR_DATA_W-1:0] csr_data = '0;

   sharpen_scoreboard sb = new();
   int burst_left = 0;
   bit steady_send = 1'b0;
   bit hold_off_request = 1'b0;
   pixel_mode_type pixel_mode = PIX_ANY;

   sharpen_edge_3x3_filter dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_pixel_in(req_pixel_in),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_out_row(rsp_out_row),
      .rsp_out_col(rsp_out_col),
      .rsp_out_value(rsp_out_value),
      .rsp_frame_done(rsp_frame_done),
      .rsp_run_last(rsp_run_last),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_index(csr_index),
      .csr_data(csr_data)
   );

   always #5 clock = ~clock;

   function automatic logic [sef_pkg::PIX_W-1:0] next_pixel(pixel_mode_type mode);
      case (mode)
         PIX_LOW: return sef_pkg::PIX_W'($urandom_range(0, 2000));
         PIX_EXTREME: return ($urandom_range(0, 1) == 1) ? '1 : '0;
         PIX_MID: return sef_pkg::PIX_W'(16'h7f00 + $urandom_range(0, 511));
         default: return sef_pkg::PIX_W'($urandom_range(0, 65535));
      endcase
   endfunction

   // One pixel word; unless steady_send is set, bursts of random length with random gaps
   task automatic send_pixel(input logic [sef_pkg::PIX_W-1:0] pix);
      int gap;
      if (!steady_send && burst_left == 0) begin
         gap = ($urandom_range(0, 7) == 0) ? $urandom_range(10, 30) : $urandom_range(0, 4);
         burst_left = $urandom_range(1, 24);
         repeat (gap) begin
            @(negedge clock);
            req_valid <= 1'b0;
         end
      end
      if (burst_left > 0) burst_left--;
      @(negedge clock);
      req_valid <= 1'b1;
      req_pixel_in <= pix;
      do @(posedge clock); while (!req_ready);
      sb.note_pixel(pix);
   endtask

   task automatic send_pixels(input int count);
      repeat (count) send_pixel(next_pixel(pixel_mode));
   endtask

   task automatic release_req();
      @(negedge clock);
      req_valid <= 1'b0;
   endtask

   // Sender pauses until every expected word is back, then lets the pipe settle
   task automatic wait_for_results();
      do @(posedge clock); while (sb.outstanding() != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input logic [sef_pkg::CSR_IDX_W-1:0] idx,
                            input logic [sef_pkg::CSR_DATA_W-1:0] d);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= d;
      do @(posedge clock); while (!csr_ready);
      sb.write_reg(idx, d);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // Field values go in the low bits, the unused upper bits are random
   task automatic configure(input int unsigned w_raw, input int unsigned h_raw,
                            input logic [sef_pkg::PIX_W-1:0] clamp);
      write_reg(sef_pkg::CSR_IMAGE_WIDTH,
                sef_pkg::CSR_DATA_W'(($urandom & 32'hfc00) | w_raw));
      write_reg(sef_pkg::CSR_IMAGE_HEIGHT,
                sef_pkg::CSR_DATA_W'(($urandom & 32'he000) | h_raw));
      write_reg(sef_pkg::CSR_MAX_VALUE, clamp);
   endtask

   // Receiver: changing ready patterns, plus a long hold-off on request
   initial begin
      ready_mode_type ready_mode;
      int mode_left;
      int tick;
      ready_mode = READY_ALWAYS;
      mode_left = 0;
      tick = 0;
      forever begin
         @(negedge clock);
         if (hold_off_request) begin
            rsp_ready <= 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock);
            hold_off_request = 1'b0;
         end else begin
            if (mode_left == 0) begin
               ready_mode = ready_mode_type'($urandom_range(0, 3));
               mode_left = $urandom_range(10, 150);
            end
            mode_left--;
            tick++;
            case (ready_mode)
               READY_ALWAYS: rsp_ready <= 1'b1;
               READY_COIN: rsp_ready <= ($urandom_range(0, 1) == 1);
               READY_PERIODIC: rsp_ready <= (tick % 3 != 0);
               default: rsp_ready <= ($urandom_range(0, 3) == 0);
            endcase
         end
      end
   end

   // Result monitor
   initial begin
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && rsp_ready)
            sb.check({rsp_out_row, rsp_out_col, rsp_out_value, rsp_frame_done, rsp_run_last});
      end
   end

   // Watchdog
   initial begin
      #5_000_000;
      $display("DONE: errors detected");
      $finish;
   end

   // Stimulus
   initial begin
      int phase;
      int counted_items;
      int frames;
      int count;
      int unsigned w_raw, h_raw;
      logic [sef_pkg::PIX_W-1:0] clamp;
      phase = 0;
      counted_items = 0;

      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Reset width: row 0 carries on past column 3
      send_pixel(16'h0000);
      send_pixel(16'hffff);
      send_pixel(16'h5555);
      send_pixel(16'haaaa);
      release_req();
      wait_for_results();
      // Spare index is ignored; then shrink the width in mid-row so the counter wraps
      write_reg(CSR_SPARE_INDEX, 16'hffff);
      write_reg(sef_pkg::CSR_IMAGE_WIDTH, 16'h0001);
      send_pixel(16'h1234);
      send_pixel(16'h8001);
      release_req();
      wait_for_results();
      // Height cut below the current row ends the frame on the next word
      write_reg(sef_pkg::CSR_IMAGE_HEIGHT, 16'h0002);
      send_pixel(16'h7ffe);
      release_req();
      wait_for_results();

      // 3x3 frames: bright center clamps high, dark center clamps at zero
      configure(3, 3, 16'hffff);
      for (int i = 0; i < 9; i++) send_pixel((i == 4) ? 16'hffff : 16'h0000);
      for (int i = 0; i < 9; i++) send_pixel((i == 4) ? 16'h0000 : 16'hffff);
      release_req();
      wait_for_results();

      // Random phases, one setting each, always starting on a frame boundary
      while (counted_items < 400) begin
         frames = 1;
         steady_send = ($urandom_range(0, 3) == 0);
         pixel_mode = pixel_mode_type'($urandom_range(0, 3));
         case ($urandom_range(0, 3))
            0: clamp = '0;
            1: clamp = 16'h00ff;
            2: clamp = '1;
            default: clamp = sef_pkg::PIX_W'($urandom_range(0, 65535));
         endcase
         case (phase)
            0: begin
               // Receiver holds off while the sender keeps offering words
               w_raw = 8;
               h_raw = 8;
               clamp = '1;
               pixel_mode = PIX_LOW;
               steady_send = 1'b1;
            end
            1: begin
               // Width above the line buffer size, row ended early by lowering the width
               w_raw = 10'h3ff;
               h_raw = 1;
            end
            2: begin
               // Tall frame, ended early by lowering the height
               w_raw = 1;
               h_raw = 13'h1fff;
            end
            3: begin
               w_raw = 0;
               h_raw = 0;
               clamp = '0;
               frames = 3;
            end
            4: begin
               w_raw = 6;
               h_raw = 5;
               clamp = '0;
               pixel_mode = PIX_LOW;
               frames = 2;
            end
            default: begin
               case ($urandom_range(0, 4))
                  0: begin
                     w_raw = $urandom_range(0, 2);
                     h_raw = $urandom_range(0, 4);
                  end
                  1: begin
                     w_raw = $urandom_range(3, 6);
                     h_raw = $urandom_range(0, 2);
                  end
                  default: begin
                     w_raw = $urandom_range(3, 16);
                     h_raw = $urandom_range(3, 10);
                  end
               endcase
               frames = $urandom_range(1, 3);
            end
         endcase
         configure(w_raw, h_raw, clamp);
         if (phase == 0) hold_off_request = 1'b1;
         if (sb.cols_now() * sb.rows_now() > 60) frames = 1;

         if (phase == 1 || phase == 2) begin
            send_pixels(40);
            release_req();
            wait_for_results();
            if (phase == 1)
               write_reg(sef_pkg::CSR_IMAGE_WIDTH,
                         sef_pkg::CSR_DATA_W'(($urandom & 32'hfc00) | 1));
            else
               write_reg(sef_pkg::CSR_IMAGE_HEIGHT,
                         sef_pkg::CSR_DATA_W'(($urandom & 32'he000) | 1));
            send_pixels(1);
            counted_items += 41;
         end else begin
            count = sb.cols_now() * sb.rows_now() * frames;
            send_pixels(count);
            counted_items += count;
         end
         release_req();
         wait_for_results();
         phase++;
      end

      steady_send = 1'b0;
      if (sb.errors == 0 && sb.outstanding() == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
